// ----- src/wsfm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfm_pkg
// Shared codes and types of the working set FIFO manager.
// ----------------------------------------------------------------------------
package wsfm_pkg;

  localparam int unsigned DefEntries  = 64;
  localparam int unsigned DefAddrBits = 48;

  localparam logic [6:0]  ResetInitLimit = 7'd32;
  localparam logic [6:0]  ResetStep      = 7'd8;
  localparam logic [31:0] ResetMinAvail  = 32'd256;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_PIN    = 3'd2,
    OP_UNPIN  = 3'd3,
    OP_TRIM   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_DUP      = 3'd3,
    ST_QEMPTY   = 3'd4,
    ST_NOVICTIM = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_INIT_LIMIT = 2'd0,
    CFG_STEP       = 2'd1,
    CFG_MIN_AVAIL  = 2'd2
  } cfg_idx_e;

  typedef enum logic [5:0] {
    FSM_IDLE    = 6'b000001,
    FSM_SCAN    = 6'b000010,
    FSM_DECIDE  = 6'b000100,
    FSM_MODIFY  = 6'b001000,
    FSM_TRIMCHK = 6'b010000,
    FSM_EMIT    = 6'b100000
  } fsm_e;

  // What the ring tap does to each entry during a modify pass.
  typedef struct packed {
    logic ev;       // evict the oldest queued entry, age the rest
    logic deq;      // close the gap left by a dequeued entry
    logic kill;     // drop the matching entry
    logic pin_set;  // pin the matching entry
    logic unpin;    // unpin the matching entry and put it at the tail
    logic place;    // store the new entry in the first free cell
  } mode_t;

endpackage

// ----- src/wsfm_if.sv -----
// ----------------------------------------------------------------------------
// wsfm interfaces
// Operation, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface wsfm_in_if #(
  parameter int unsigned AW = wsfm_pkg::DefAddrBits
);
  logic          valid;
  logic          ready;
  logic [2:0]    opcode;
  logic [AW-1:0] page_addr;
  logic          is_table_page;
  logic          pin_on_insert;
  logic [5:0]    trim_count;
  logic [31:0]   avail_pages;

  modport source (output valid, opcode, page_addr, is_table_page, pin_on_insert,
                  trim_count, avail_pages, input ready);
  modport sink   (input valid, opcode, page_addr, is_table_page, pin_on_insert,
                  trim_count, avail_pages, output ready);
endinterface

interface wsfm_out_if #(
  parameter int unsigned AW = wsfm_pkg::DefAddrBits
);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [AW-1:0] evicted_addr;
  logic          evicted_is_table;
  logic [5:0]    trimmed_total;
  logic [6:0]    entry_count;
  logic [6:0]    pinned_count;
  logic [6:0]    size_limit;
  logic          last;

  modport source (output valid, status, evicted_addr, evicted_is_table, trimmed_total,
                  entry_count, pinned_count, size_limit, last, input ready);
  modport sink   (input valid, status, evicted_addr, evicted_is_table, trimmed_total,
                  entry_count, pinned_count, size_limit, last, output ready);
endinterface

interface wsfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/working_set_fifo_manager.sv -----
// ----------------------------------------------------------------------------
// working_set_fifo_manager
// Bounded working set of page addresses with FIFO eviction of unpinned pages.
// ----------------------------------------------------------------------------
// Usage: operations arrive as words on in_i (insert, remove, pin, unpin, trim)
// and results leave as words on out_o; every operation but trim gives one
// word with last set; trim gives one word per evicted entry and a final
// queue-empty word if the queue runs out. Registers are written through
// cfg_i (always ready); the user must write them while the block is idle,
// which the block does not enforce. Entries live in a ring of ENTRIES cells
// that rotates one cell per cycle while scanning or modifying, past a single
// tap; each entry carries its queue rank, so the oldest queued entry is the
// one with rank zero. Insert, remove, pin and unpin scan the ring and then
// modify it; a duplicate or missing address is answered after the scan. Each
// trim eviction is one modify pass. One operation is worked on at a time;
// in_i is ready only when idle. Reset: all cells invalid, counts zero, limit
// from initial_limit. A stalled result holds in the output register and the
// ring waits until the word is taken.
// ----------------------------------------------------------------------------
module working_set_fifo_manager #(
  parameter int unsigned ENTRIES   = wsfm_pkg::DefEntries,
  parameter int unsigned ADDR_BITS = wsfm_pkg::DefAddrBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  wsfm_in_if.sink    in_i,
  wsfm_out_if.source out_o,
  wsfm_cfg_if.sink   cfg_i
);

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = ((CW > 7) ? CW : 7) + 1;
  localparam logic [RW-1:0] LastCnt = RW'(ENTRIES - 1);

  // ring
  logic          c_valid  [ENTRIES];
  logic          c_pinned [ENTRIES];
  logic          c_tbl    [ENTRIES];
  logic [RW-1:0] c_rank   [ENTRIES];
  logic [ADDR_BITS-1:0] c_addr [ENTRIES];

  logic          n_valid, n_pinned, n_tbl;
  logic [RW-1:0] n_rank;
  logic [ADDR_BITS-1:0] n_addr;
  logic          shift;

  wsfm_pkg::fsm_e st_q, st_d, ret_q, ret_d;
  logic [2:0]           op_q, op_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic                 tbl_q, tbl_d, pin_q, pin_d;
  logic [5:0]           tcnt_q, tcnt_d, tdone_q, tdone_d;
  logic [31:0]          avail_q, avail_d;
  logic [RW-1:0]        cnt_q, cnt_d, frank_q, frank_d, nrank_q, nrank_d;
  logic                 found_q, found_d, fpin_q, fpin_d, placed_q, placed_d;
  wsfm_pkg::mode_t      mode_q, mode_d;
  logic [ADDR_BITS-1:0] cap_addr_q, cap_addr_d;
  logic                 cap_tbl_q, cap_tbl_d;
  logic [CW-1:0]        held_q, held_d, pinned_q, pinned_d, qlen_q, qlen_d;
  logic [CW-1:0]        limit_q, limit_d;
  logic [6:0]           step_q;
  logic [31:0]          thr_q;

  logic [2:0]           res_status_q, res_status_d;
  logic [ADDR_BITS-1:0] res_addr_q, res_addr_d;
  logic                 res_tbl_q, res_tbl_d, res_last_q, res_last_d;
  logic [5:0]           res_trim_q, res_trim_d;

  logic                 out_valid_q;
  logic [2:0]           out_status_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  logic                 out_tbl_q, out_last_q;
  logic [5:0]           out_trim_q;
  logic [6:0]           out_held_q, out_pinned_q, out_limit_q;

  logic          t_queued, t_match, load_out;
  logic [SW-1:0] grow_sum, cfg_lim;
  logic [CW-1:0] lim_new, h_tmp, q_tmp;
  logic          need_ev;
  logic [5:0]    tnext;

  assign shift = (st_q == wsfm_pkg::FSM_SCAN) || (st_q == wsfm_pkg::FSM_MODIFY);

  for (genvar k = 0; k < ENTRIES; k++) begin : g_ring
    if (k == 0) begin : g_head
      wsfm_cell #(.AW(ADDR_BITS), .RW(RW)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(n_valid), .pinned_i(n_pinned), .tbl_i(n_tbl),
        .rank_i(n_rank), .addr_i(n_addr),
        .valid_o(c_valid[k]), .pinned_o(c_pinned[k]), .tbl_o(c_tbl[k]),
        .rank_o(c_rank[k]), .addr_o(c_addr[k])
      );
    end else begin : g_body
      wsfm_cell #(.AW(ADDR_BITS), .RW(RW)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(c_valid[k-1]), .pinned_i(c_pinned[k-1]), .tbl_i(c_tbl[k-1]),
        .rank_i(c_rank[k-1]), .addr_i(c_addr[k-1]),
        .valid_o(c_valid[k]), .pinned_o(c_pinned[k]), .tbl_o(c_tbl[k]),
        .rank_o(c_rank[k]), .addr_o(c_addr[k])
      );
    end
  end

  // tap: entry leaving the last cell, rewritten on its way into the first
  assign t_queued = c_valid[ENTRIES-1] && !c_pinned[ENTRIES-1];
  assign t_match  = c_valid[ENTRIES-1] && (c_addr[ENTRIES-1] == addr_q);

  always_comb begin
    n_valid    = c_valid[ENTRIES-1];
    n_pinned   = c_pinned[ENTRIES-1];
    n_tbl      = c_tbl[ENTRIES-1];
    n_rank     = c_rank[ENTRIES-1];
    n_addr     = c_addr[ENTRIES-1];
    placed_d   = placed_q;
    cap_addr_d = cap_addr_q;
    cap_tbl_d  = cap_tbl_q;
    if (st_q == wsfm_pkg::FSM_MODIFY) begin
      if (mode_q.ev && t_queued) begin
        if (n_rank == '0) begin
          cap_addr_d = n_addr;
          cap_tbl_d  = n_tbl;
          n_valid    = 1'b0;
        end else begin
          n_rank = n_rank - 1'b1;
        end
      end
      if (mode_q.deq && t_queued && (n_rank > frank_q)) n_rank = n_rank - 1'b1;
      if (t_match && mode_q.kill) begin
        n_valid  = 1'b0;
        n_pinned = 1'b0;
      end
      if (t_match && mode_q.pin_set) n_pinned = 1'b1;
      if (t_match && mode_q.unpin) begin
        n_pinned = 1'b0;
        n_rank   = nrank_q;
      end
      if (mode_q.place && !placed_q && !n_valid) begin
        n_valid  = 1'b1;
        n_pinned = pin_q;
        n_tbl    = tbl_q;
        n_rank   = nrank_q;
        n_addr   = addr_q;
        placed_d = 1'b1;
      end
    end
  end

  assign grow_sum = SW'(limit_q) + SW'(step_q);
  assign cfg_lim  = SW'(cfg_i.data[6:0]);
  assign load_out = (st_q == wsfm_pkg::FSM_EMIT) && (!out_valid_q || out_o.ready);
  assign tnext    = tdone_q + 6'd1;

  always_comb begin
    st_d = st_q; ret_d = ret_q; op_d = op_q; addr_d = addr_q; tbl_d = tbl_q;
    pin_d = pin_q; tcnt_d = tcnt_q; tdone_d = tdone_q; avail_d = avail_q;
    cnt_d = cnt_q; frank_d = frank_q; nrank_d = nrank_q; found_d = found_q;
    fpin_d = fpin_q; mode_d = mode_q;
    held_d = held_q; pinned_d = pinned_q; qlen_d = qlen_q; limit_d = limit_q;
    res_status_d = res_status_q; res_addr_d = res_addr_q; res_tbl_d = res_tbl_q;
    res_trim_d = res_trim_q; res_last_d = res_last_q;
    lim_new = limit_q; need_ev = 1'b0; h_tmp = held_q; q_tmp = qlen_q;

    unique case (st_q)
      wsfm_pkg::FSM_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.opcode;
          addr_d  = in_i.page_addr;
          tbl_d   = in_i.is_table_page;
          pin_d   = in_i.pin_on_insert;
          tcnt_d  = in_i.trim_count;
          avail_d = in_i.avail_pages;
          cnt_d   = '0;
          found_d = 1'b0;
          tdone_d = '0;
          res_status_d = wsfm_pkg::ST_OK;
          res_addr_d = '0; res_tbl_d = 1'b0; res_trim_d = '0; res_last_d = 1'b1;
          ret_d = wsfm_pkg::FSM_IDLE;
          if (in_i.opcode <= wsfm_pkg::OP_UNPIN) st_d = wsfm_pkg::FSM_SCAN;
          else if (in_i.opcode == wsfm_pkg::OP_TRIM && in_i.trim_count != '0)
            st_d = wsfm_pkg::FSM_TRIMCHK;
          else st_d = wsfm_pkg::FSM_EMIT;
        end
      end
      wsfm_pkg::FSM_SCAN: begin
        if (t_match) begin
          found_d = 1'b1;
          frank_d = c_rank[ENTRIES-1];
          fpin_d  = c_pinned[ENTRIES-1];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) st_d = wsfm_pkg::FSM_DECIDE;
      end
      wsfm_pkg::FSM_DECIDE: begin
        mode_d = '0;
        cnt_d  = '0;
        st_d   = wsfm_pkg::FSM_EMIT;
        if (op_q == wsfm_pkg::OP_INSERT) begin
          if (found_q) res_status_d = wsfm_pkg::ST_DUP;
          else begin
            if (held_q >= limit_q && avail_q > thr_q)
              lim_new = (grow_sum > SW'(ENTRIES)) ? CW'(ENTRIES) : CW'(grow_sum);
            limit_d = lim_new;
            need_ev = held_q >= lim_new;
            if (need_ev && qlen_q == '0) res_status_d = wsfm_pkg::ST_NOVICTIM;
            else begin
              if (need_ev) begin
                mode_d.ev = 1'b1;
                q_tmp = q_tmp - 1'b1;
                h_tmp = h_tmp - 1'b1;
              end
              h_tmp = h_tmp + 1'b1;
              if (pin_q) pinned_d = pinned_q + 1'b1;
              else begin
                nrank_d = RW'(q_tmp);
                q_tmp   = q_tmp + 1'b1;
              end
              held_d = h_tmp;
              qlen_d = q_tmp;
              mode_d.place = 1'b1;
              st_d = wsfm_pkg::FSM_MODIFY;
            end
          end
        end else if (!found_q) begin
          res_status_d = wsfm_pkg::ST_NOTFOUND;
        end else begin
          st_d = wsfm_pkg::FSM_MODIFY;
          if (op_q == wsfm_pkg::OP_REMOVE) begin
            mode_d.kill = 1'b1;
            if (fpin_q) pinned_d = pinned_q - 1'b1;
            else begin
              mode_d.deq = 1'b1;
              qlen_d = qlen_q - 1'b1;
            end
            held_d = held_q - 1'b1;
          end else if (op_q == wsfm_pkg::OP_PIN) begin
            if (!fpin_q) begin
              mode_d.deq = 1'b1;
              mode_d.pin_set = 1'b1;
              qlen_d = qlen_q - 1'b1;
              pinned_d = pinned_q + 1'b1;
            end
          end else if (fpin_q) begin
            mode_d.unpin = 1'b1;
            nrank_d = RW'(qlen_q);
            qlen_d = qlen_q + 1'b1;
            pinned_d = pinned_q - 1'b1;
          end
        end
      end
      wsfm_pkg::FSM_MODIFY: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          st_d = wsfm_pkg::FSM_EMIT;
          res_status_d = wsfm_pkg::ST_OK;
          res_addr_d = '0; res_tbl_d = 1'b0; res_trim_d = '0; res_last_d = 1'b1;
          ret_d = wsfm_pkg::FSM_IDLE;
          if (mode_q.ev) begin
            res_status_d = wsfm_pkg::ST_EVICTED;
            res_addr_d = cap_addr_d;
            res_tbl_d  = cap_tbl_d;
          end
          if (op_q == wsfm_pkg::OP_TRIM) begin
            res_trim_d = tnext;
            tdone_d    = tnext;
            res_last_d = (tnext == tcnt_q);
            if (tnext != tcnt_q) ret_d = wsfm_pkg::FSM_TRIMCHK;
          end
        end
      end
      wsfm_pkg::FSM_TRIMCHK: begin
        if (qlen_q == '0) begin
          res_status_d = wsfm_pkg::ST_QEMPTY;
          res_addr_d = '0; res_tbl_d = 1'b0; res_trim_d = tdone_q; res_last_d = 1'b1;
          ret_d = wsfm_pkg::FSM_IDLE;
          st_d  = wsfm_pkg::FSM_EMIT;
        end else begin
          qlen_d = qlen_q - 1'b1;
          held_d = held_q - 1'b1;
          mode_d = '0;
          mode_d.ev = 1'b1;
          cnt_d = '0;
          st_d  = wsfm_pkg::FSM_MODIFY;
        end
      end
      wsfm_pkg::FSM_EMIT: begin
        if (load_out) st_d = ret_q;
      end
      default: st_d = wsfm_pkg::FSM_IDLE;
    endcase

    // a write of initial_limit reloads the live limit
    if (cfg_i.valid && cfg_i.index == wsfm_pkg::CFG_INIT_LIMIT)
      limit_d = (cfg_lim > SW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cfg_i.data[6:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= wsfm_pkg::FSM_IDLE;
      ret_q       <= wsfm_pkg::FSM_IDLE;
      mode_q      <= '0;
      placed_q    <= 1'b0;
      held_q      <= '0;
      pinned_q    <= '0;
      qlen_q      <= '0;
      limit_q     <= (SW'(wsfm_pkg::ResetInitLimit) > SW'(ENTRIES)) ? CW'(ENTRIES)
                     : CW'(wsfm_pkg::ResetInitLimit);
      step_q      <= wsfm_pkg::ResetStep;
      thr_q       <= wsfm_pkg::ResetMinAvail;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      ret_q    <= ret_d;
      mode_q   <= mode_d;
      placed_q <= (st_q == wsfm_pkg::FSM_MODIFY) ? placed_d : 1'b0;
      held_q   <= held_d;
      pinned_q <= pinned_d;
      qlen_q   <= qlen_d;
      limit_q  <= limit_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          wsfm_pkg::CFG_INIT_LIMIT: ;
          wsfm_pkg::CFG_STEP:      step_q <= cfg_i.data[6:0];
          wsfm_pkg::CFG_MIN_AVAIL: thr_q  <= cfg_i.data;
          default: ;
        endcase
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; addr_q <= addr_d; tbl_q <= tbl_d; pin_q <= pin_d;
    tcnt_q <= tcnt_d; tdone_q <= tdone_d; avail_q <= avail_d; cnt_q <= cnt_d;
    frank_q <= frank_d; nrank_q <= nrank_d; found_q <= found_d; fpin_q <= fpin_d;
    cap_addr_q <= cap_addr_d; cap_tbl_q <= cap_tbl_d;
    res_status_q <= res_status_d; res_addr_q <= res_addr_d; res_tbl_q <= res_tbl_d;
    res_trim_q <= res_trim_d; res_last_q <= res_last_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_tbl_q    <= res_tbl_q;
      out_trim_q   <= res_trim_q;
      out_last_q   <= res_last_q;
      out_held_q   <= 7'(held_q);
      out_pinned_q <= 7'(pinned_q);
      out_limit_q  <= 7'(limit_q);
    end
  end

  assign in_i.ready  = (st_q == wsfm_pkg::FSM_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.evicted_addr     = out_addr_q;
  assign out_o.evicted_is_table = out_tbl_q;
  assign out_o.trimmed_total    = out_trim_q;
  assign out_o.entry_count      = out_held_q;
  assign out_o.pinned_count     = out_pinned_q;
  assign out_o.size_limit       = out_limit_q;
  assign out_o.last             = out_last_q;

endmodule

// ----- src/wsfm_cell.sv -----
// ----------------------------------------------------------------------------
// wsfm_cell
// One slot of the entry ring; takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module wsfm_cell #(
  parameter int unsigned AW = wsfm_pkg::DefAddrBits,
  parameter int unsigned RW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          valid_i,
  input  logic          pinned_i,
  input  logic          tbl_i,
  input  logic [RW-1:0] rank_i,
  input  logic [AW-1:0] addr_i,
  output logic          valid_o,
  output logic          pinned_o,
  output logic          tbl_o,
  output logic [RW-1:0] rank_o,
  output logic [AW-1:0] addr_o
);

  logic          valid_q, pinned_q, tbl_q;
  logic [RW-1:0] rank_q;
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      pinned_q <= 1'b0;
    end else if (shift_i) begin
      valid_q  <= valid_i;
      pinned_q <= pinned_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tbl_q  <= tbl_i;
      rank_q <= rank_i;
      addr_q <= addr_i;
    end
  end

  assign valid_o  = valid_q;
  assign pinned_o = pinned_q;
  assign tbl_o    = tbl_q;
  assign rank_o   = rank_q;
  assign addr_o   = addr_q;

endmodule

// ----- src/wsfm_checker.sv -----
// ----------------------------------------------------------------------------
// wsfm_checker
// Port-level checks of the working set FIFO manager, bound to the top level.
// ----------------------------------------------------------------------------
module wsfm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       last,
  input logic [6:0] entry_count,
  input logic [6:0] pinned_count,
  input logic       in_ready
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
    else $error("result word dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status <= wsfm_pkg::ST_NOVICTIM)
    else $error("undefined status code");

  // only trim evictions may be followed by more words
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last |-> status == wsfm_pkg::ST_EVICTED)
    else $error("non-final word is not an eviction");

  a_pinned_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pinned_count <= entry_count)
    else $error("more pinned entries than held entries");

  // no new operation while a non-final word is pending
  a_busy_in_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last |-> !in_ready)
    else $error("input accepted in the middle of a trim");

endmodule

bind working_set_fifo_manager wsfm_checker u_wsfm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .status       (out_o.status),
  .last         (out_o.last),
  .entry_count  (out_o.entry_count),
  .pinned_count (out_o.pinned_count),
  .in_ready     (in_i.ready)
);
